// ===== src/umidi_pkg.sv =====
// shared types, constants and defaults for the usb-midi packet deframer
package umidi_pkg;

  localparam int CABLE_COUNT_DEF = 16;
  localparam int FIFO_DEPTH_DEF  = 64;

  localparam logic [31:0] SIZE_TABLE_RESET = 32'h7AFF_E7E0;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_WRITE,
    ST_RDWAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic latch;
    logic eval;
    logic wr_step;
    logic rd_cap;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic push_wr;
    logic read_hit;
    logic wr_last;
    logic out_free;
  } sts_t;

endpackage

// ===== src/umidi_if.sv =====
// channel interfaces: event/read requests, results and size table writes
interface umidi_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] packet_header;
  logic [7:0] payload_byte0;
  logic [7:0] payload_byte1;
  logic [7:0] payload_byte2;
  logic [3:0] read_cable;

  modport source (output valid, operation, packet_header, payload_byte0, payload_byte1,
                  payload_byte2, read_cable, input ready);
  modport sink (input valid, operation, packet_header, payload_byte0, payload_byte1,
                payload_byte2, read_cable, output ready);
endinterface

interface umidi_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_byte;
  logic       read_valid;
  logic [1:0] bytes_queued;
  logic       packet_dropped;

  modport source (output valid, read_byte, read_valid, bytes_queued, packet_dropped,
                  input ready);
  modport sink (input valid, read_byte, read_valid, bytes_queued, packet_dropped,
                output ready);
endinterface

interface umidi_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] size_table;

  modport source (output valid, size_table, input ready);
  modport sink (input valid, size_table, output ready);
endinterface

// ===== src/umidi_ram.sv =====
// generic single-port ram with registered read
module umidi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/umidi_ctrl.sv =====
// controller state machine sequencing accept, evaluate, byte writes and result load
module umidi_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  umidi_pkg::sts_t sts,
  output umidi_pkg::cmd_t cmd
);
  import umidi_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        priority if (sts.read_hit) state_nxt = ST_RDWAIT;
        else if (sts.push_wr) state_nxt = ST_WRITE;
        else state_nxt = ST_DONE;
      end
      ST_WRITE: begin
        if (sts.wr_last) state_nxt = ST_DONE;
      end
      ST_RDWAIT: state_nxt = ST_DONE;
      ST_DONE: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      ST_EVAL:   cmd.eval = 1'b1;
      ST_WRITE:  cmd.wr_step = 1'b1;
      ST_RDWAIT: cmd.rd_cap = 1'b1;
      ST_DONE:   cmd.out_load = sts.out_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== src/umidi_dp.sv =====
// datapath: request latch, ring indexes, fifo memory, size table and result registers
module umidi_dp #(
  parameter int CABLE_COUNT = umidi_pkg::CABLE_COUNT_DEF,
  parameter int FIFO_DEPTH  = umidi_pkg::FIFO_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  umidi_pkg::cmd_t cmd,
  output umidi_pkg::sts_t sts,
  input  logic            in_operation,
  input  logic [7:0]      in_packet_header,
  input  logic [7:0]      in_payload_byte0,
  input  logic [7:0]      in_payload_byte1,
  input  logic [7:0]      in_payload_byte2,
  input  logic [3:0]      in_read_cable,
  input  logic            cfg_valid,
  input  logic [31:0]     cfg_size_table,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_read_byte,
  output logic            out_read_valid,
  output logic [1:0]      out_bytes_queued,
  output logic            out_packet_dropped
);
  import umidi_pkg::*;

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int UW = PW + 1;
  localparam int CW = (CABLE_COUNT > 1) ? $clog2(CABLE_COUNT) : 1;
  localparam int MD = CABLE_COUNT * FIFO_DEPTH;
  localparam int AW = $clog2(MD);
  localparam logic [UW-1:0] DEPTH_U = UW'(FIFO_DEPTH);
  localparam logic [PW-1:0] LAST_POS = PW'(FIFO_DEPTH - 1);

  function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] pos);
    return (pos == LAST_POS) ? '0 : pos + 1'b1;
  endfunction

  function automatic logic [AW-1:0] mk_addr(input logic [CW-1:0] c, input logic [PW-1:0] p);
    return AW'(c) * AW'(FIFO_DEPTH) + AW'(p);
  endfunction

  logic [31:0]   size_table_r;
  logic          op_r;
  logic [7:0]    hdr_r;
  logic [7:0]    pay0_r, pay1_r, pay2_r;
  logic [3:0]    rcab_r;
  logic [CW-1:0] cab_r;
  logic [1:0]    size_r;
  logic [1:0]    cnt_r;
  logic [7:0]    res_byte_r;
  logic          res_valid_r;
  logic [1:0]    res_queued_r;
  logic          res_drop_r;
  logic          out_valid_r;
  logic [7:0]    out_byte_r;
  logic          out_rvalid_r;
  logic [1:0]    out_queued_r;
  logic          out_drop_r;
  logic [PW-1:0] wr_idx_r [CABLE_COUNT];
  logic [PW-1:0] rd_idx_r [CABLE_COUNT];

  logic          is_read;
  logic [3:0]    sel_cable;
  logic          present;
  logic [CW-1:0] cab_idx;
  logic [PW-1:0] w_pos, r_pos, wb_pos;
  logic [UW-1:0] used;
  logic [UW-1:0] free_cnt;
  logic [1:0]    size;
  logic          hdr_zero;
  logic          room_ok;
  logic          push_ok;
  logic          read_hit;
  logic [7:0]    wr_byte;
  logic          ram_en;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_rdata;

  assign is_read   = (op_r == OP_READ);
  assign sel_cable = is_read ? rcab_r : hdr_r[7:4];
  assign present   = {1'b0, sel_cable} < 5'(CABLE_COUNT);
  assign cab_idx   = sel_cable[CW-1:0];
  assign w_pos     = wr_idx_r[cab_idx];
  assign r_pos     = rd_idx_r[cab_idx];
  assign used      = (w_pos >= r_pos) ? ({1'b0, w_pos} - {1'b0, r_pos})
                                      : ({1'b0, w_pos} + DEPTH_U - {1'b0, r_pos});
  assign free_cnt  = DEPTH_U - UW'(1) - used;
  assign size      = 2'(size_table_r >> {hdr_r[3:0], 1'b0});
  assign hdr_zero  = (hdr_r == 8'd0);
  assign room_ok   = free_cnt >= UW'(size);
  assign push_ok   = !is_read && !hdr_zero && present && room_ok;
  assign read_hit  = is_read && present && (w_pos != r_pos);

  assign wb_pos = wr_idx_r[cab_r];

  always_comb begin
    unique case (cnt_r)
      2'd0:    wr_byte = pay0_r;
      2'd1:    wr_byte = pay1_r;
      default: wr_byte = pay2_r;
    endcase
  end

  assign sts.push_wr  = push_ok && (size != 2'd0);
  assign sts.read_hit = read_hit;
  assign sts.wr_last  = (cnt_r == size_r - 2'd1);
  assign sts.out_free = !out_valid_r || out_ready;

  assign ram_en   = (cmd.eval && read_hit) || cmd.wr_step;
  assign ram_addr = cmd.wr_step ? mk_addr(cab_r, wb_pos) : mk_addr(cab_idx, r_pos);

  umidi_ram #(
    .WIDTH(8),
    .DEPTH(MD)
  ) u_ram (
    .clk  (clk),
    .en   (ram_en),
    .we   (cmd.wr_step),
    .addr (ram_addr),
    .wdata(wr_byte),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_table_r <= SIZE_TABLE_RESET;
    end else if (cfg_valid) begin
      size_table_r <= cfg_size_table;
    end
  end

  // request latch and per-item work registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r   <= in_operation;
      hdr_r  <= in_packet_header;
      pay0_r <= in_payload_byte0;
      pay1_r <= in_payload_byte1;
      pay2_r <= in_payload_byte2;
      rcab_r <= in_read_cable;
    end
    if (cmd.eval) begin
      cab_r        <= cab_idx;
      size_r       <= size;
      cnt_r        <= 2'd0;
      res_byte_r   <= 8'd0;
      res_valid_r  <= read_hit;
      res_queued_r <= push_ok ? size : 2'd0;
      res_drop_r   <= !is_read && !hdr_zero && !(present && room_ok);
    end
    if (cmd.wr_step) begin
      cnt_r <= cnt_r + 2'd1;
    end
    if (cmd.rd_cap) begin
      res_byte_r <= ram_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CABLE_COUNT; i++) begin
        wr_idx_r[i] <= '0;
        rd_idx_r[i] <= '0;
      end
    end else begin
      if (cmd.eval && read_hit) begin
        rd_idx_r[cab_idx] <= ring_next(r_pos);
      end
      if (cmd.wr_step) begin
        wr_idx_r[cab_r] <= ring_next(wb_pos);
      end
    end
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_byte_r   <= res_byte_r;
      out_rvalid_r <= res_valid_r;
      out_queued_r <= res_queued_r;
      out_drop_r   <= res_drop_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_read_byte      = out_byte_r;
  assign out_read_valid     = out_rvalid_r;
  assign out_bytes_queued   = out_queued_r;
  assign out_packet_dropped = out_drop_r;

endmodule

// ===== src/usb_midi_packet_to_cable_fifos.sv =====
// top level of the usb-midi event packet deframer with per-cable byte fifos
//
// in_bus carries one request beat: operation 0 pushes a 4-byte event packet
// (header plus three payload bytes), operation 1 reads one byte from the
// fifo of read_cable. every request yields exactly one beat on out_bus.
// cfg_bus writes the packed 2-bit size table; it is always ready. the user
// must write it only while no request is in flight; the block does not enforce it.
// after a request is accepted it is evaluated; a push then writes its size
// bytes, a read that hits captures its byte in a wait state, and nothing is
// moved on a zero header, drop or miss; the single fifo ram port moves one
// byte per cycle. the result is then loaded once the output register is
// free, and the next request is taken in the cycle after the load.
// the result sits in an output register, so a new request is taken while
// the previous beat waits; a further result waits until out_bus drains.
// reset clears all ring indexes (every fifo empty), the result valid flag
// and the size table to its standard value; ram contents are not cleared.
module usb_midi_packet_to_cable_fifos #(
  parameter int CABLE_COUNT = umidi_pkg::CABLE_COUNT_DEF,
  parameter int FIFO_DEPTH  = umidi_pkg::FIFO_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  umidi_in_if.sink    in_bus,
  umidi_out_if.source out_bus,
  umidi_cfg_if.sink   cfg_bus
);
  import umidi_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_bus.ready = 1'b1;

  umidi_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_bus.valid),
    .in_ready(in_bus.ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  umidi_dp #(
    .CABLE_COUNT(CABLE_COUNT),
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_operation      (in_bus.operation),
    .in_packet_header  (in_bus.packet_header),
    .in_payload_byte0  (in_bus.payload_byte0),
    .in_payload_byte1  (in_bus.payload_byte1),
    .in_payload_byte2  (in_bus.payload_byte2),
    .in_read_cable     (in_bus.read_cable),
    .cfg_valid         (cfg_bus.valid),
    .cfg_size_table    (cfg_bus.size_table),
    .out_valid         (out_bus.valid),
    .out_ready         (out_bus.ready),
    .out_read_byte     (out_bus.read_byte),
    .out_read_valid    (out_bus.read_valid),
    .out_bytes_queued  (out_bus.bytes_queued),
    .out_packet_dropped(out_bus.packet_dropped)
  );

endmodule
